>>> design/xrs_pkg.sv
// Package for the xoshiro256+ random source: types, codes and constants.
package xrs_pkg;

  localparam logic [63:0] SmGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SmMul1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SmMul2  = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned Xs1Shift   = 30;
  localparam int unsigned Xs2Shift   = 27;
  localparam int unsigned Xs3Shift   = 31;
  localparam int unsigned AdvShift   = 17;
  localparam int unsigned AdvRot     = 45;
  localparam int unsigned FracShift  = 11;
  localparam int unsigned FracW      = 53;

  localparam int unsigned ProgLen = 15;
  localparam int unsigned PcW     = $clog2(ProgLen);

  typedef logic [PcW-1:0] pc_t;
  typedef logic [3:0][63:0] gen_t;

  typedef enum logic [1:0] {
    OP_SEED      = 2'd0,
    OP_DRAW      = 2'd1,
    OP_REPEAT    = 2'd2,
    OP_SEED_DRAW = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    U_NOP,
    U_LDZ,
    U_XS1,
    U_MLL,
    U_MLH,
    U_MHL,
    U_XS2,
    U_MIXST,
    U_ADV,
    U_ADVD,
    U_EMIT,
    U_FIN
  } uop_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_FIRST,
    C_SEED_ONLY
  } cond_e;

  typedef struct packed {
    uop_e  uop;
    logic  csel;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic first_pass;
    logic seed_only;
  } seq_flags_t;

  localparam pc_t PcMix    = pc_t'(0);
  localparam pc_t PcDraw   = pc_t'(11);
  localparam pc_t PcRepeat = pc_t'(13);
  localparam pc_t PcFin    = pc_t'(14);

endpackage

>>> design/xrs_in_if.sv
// Request channel: opcode and seed.
interface xrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

>>> design/xrs_out_if.sv
// Result channel: fraction and raw draw.
interface xrs_out_if;
  logic        valid;
  logic        ready;
  logic [52:0] sample_fraction;
  logic [63:0] raw_word;

  modport source (output valid, output sample_fraction, output raw_word, input ready);
  modport sink (input valid, input sample_fraction, input raw_word, output ready);
endinterface

>>> design/xrs_seq.sv
// Microcode sequencer: control store, step counter and jump logic.
module xrs_seq import xrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  pc_t        start_pc_i,
  input  seq_flags_t flags_i,
  input  logic       stall_i,
  output ucode_t     ctrl_o,
  output logic       busy_o,
  output logic       fin_o
);

  function automatic ucode_t rom(pc_t a);
    ucode_t w;
    w = '{uop: U_FIN, csel: 1'b0, cond: C_NEXT, target: PcFin};
    unique case (a)
      pc_t'(0):  w = '{uop: U_LDZ,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(1):  w = '{uop: U_XS1,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(2):  w = '{uop: U_MLL,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(3):  w = '{uop: U_MLH,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(4):  w = '{uop: U_MHL,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(5):  w = '{uop: U_XS2,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(6):  w = '{uop: U_MLL,   csel: 1'b1, cond: C_NEXT,      target: PcMix};
      pc_t'(7):  w = '{uop: U_MLH,   csel: 1'b1, cond: C_NEXT,      target: PcMix};
      pc_t'(8):  w = '{uop: U_MHL,   csel: 1'b1, cond: C_NEXT,      target: PcMix};
      pc_t'(9):  w = '{uop: U_MIXST, csel: 1'b0, cond: C_FIRST,     target: PcMix};
      pc_t'(10): w = '{uop: U_NOP,   csel: 1'b0, cond: C_SEED_ONLY, target: PcFin};
      pc_t'(11): w = '{uop: U_ADV,   csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(12): w = '{uop: U_ADVD,  csel: 1'b0, cond: C_NEXT,      target: PcMix};
      pc_t'(13): w = '{uop: U_EMIT,  csel: 1'b0, cond: C_NEXT,      target: PcMix};
      default:   w = '{uop: U_FIN,   csel: 1'b0, cond: C_NEXT,      target: PcFin};
    endcase
    return w;
  endfunction

  pc_t    pc_q, pc_d;
  logic   busy_q, busy_d;
  ucode_t ctrl;
  logic   last_step;
  logic   jump;

  assign ctrl      = rom(pc_q);
  assign last_step = (ctrl.uop == U_FIN) || (ctrl.uop == U_ADVD) || (ctrl.uop == U_EMIT);
  assign fin_o     = busy_q && last_step && !stall_i;
  assign ctrl_o    = ctrl;
  assign busy_o    = busy_q;

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_FIRST:     jump = flags_i.first_pass;
      C_SEED_ONLY: jump = flags_i.seed_only;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = start_pc_i;
      busy_d = 1'b1;
    end else if (fin_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !stall_i) begin
      pc_d = jump ? ctrl.target : pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PcFin;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < pc_t'(ProgLen)))
    else $error("step counter out of program");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && busy_q |-> fin_o)
    else $error("start while a program is running");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && stall_i |=> busy_q && $stable(pc_q))
    else $error("sequencer moved during stall");

endmodule

>>> design/xoshiro256plus_random_source_unit.sv
// xoshiro256+ random source with splitmix64 seeding, microcoded datapath.
// At most one result per request; a seed-only request gives none. A draw
// takes two generator advances, a repeat re-emits the last draw. Seeding runs
// two splitmix64 passes of ten microcode steps each, where each 64-bit product
// is built from three partial products on one shared 32x32 multiplier. A new
// request is taken in the cycle the current program ends; a finished result
// waits in the output register while the next request is worked on.
module xoshiro256plus_random_source_unit import xrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrs_in_if.sink    req_i,
  xrs_out_if.source rsp_o
);

  function automatic gen_t advance(gen_t g);
    gen_t        n;
    logic [63:0] t;
    n    = g;
    t    = n[1] << AdvShift;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = (n[3] << AdvRot) | (n[3] >> (64 - AdvRot));
    return n;
  endfunction

  ucode_t      ctrl;
  logic        busy;
  logic        fin;
  logic        stall;
  logic        accept;
  logic        step;
  seq_flags_t  flags;
  pc_t         start_pc;

  op_e         op_q, op_d;
  logic [63:0] seed_q, seed_d;
  logic        pass_q, pass_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  gen_t        g_q, g_d;
  logic [63:0] last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [52:0] out_frac_q, out_frac_d;
  logic [63:0] out_raw_q, out_raw_d;

  logic [63:0] mul_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] mix_out;
  logic [63:0] sum;
  logic        emit;

  assign emit   = (ctrl.uop == U_ADVD) || (ctrl.uop == U_EMIT);
  assign stall  = busy && emit && out_valid_q && !rsp_o.ready;
  assign step   = busy && !stall;
  assign req_i.ready = !busy || fin;
  assign accept = req_i.valid && req_i.ready;

  assign flags.first_pass = !pass_q;
  assign flags.seed_only  = (op_q == OP_SEED);

  always_comb begin
    unique case (op_e'(req_i.opcode))
      OP_SEED, OP_SEED_DRAW: start_pc = PcMix;
      OP_DRAW:               start_pc = PcDraw;
      OP_REPEAT:             start_pc = PcRepeat;
      default:               start_pc = PcFin;
    endcase
  end

  xrs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .start_pc_i (start_pc),
    .flags_i    (flags),
    .stall_i    (stall),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .fin_o      (fin)
  );

  assign mul_c   = ctrl.csel ? SmMul2 : SmMul1;
  assign mul_a   = (ctrl.uop == U_MHL) ? z_q[63:32] : z_q[31:0];
  assign mul_b   = (ctrl.uop == U_MLH) ? mul_c[63:32] : mul_c[31:0];
  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign mix_out = z_q ^ (z_q >> Xs3Shift);
  assign sum     = g_q[0] + g_q[3];

  always_comb begin
    op_d        = op_q;
    seed_d      = seed_q;
    pass_d      = pass_q;
    z_d         = z_q;
    acc_d       = acc_q;
    g_d         = g_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_frac_d  = out_frac_q;
    out_raw_d   = out_raw_q;

    if (step) begin
      case (ctrl.uop)
        U_LDZ:  z_d = pass_q ? seed_q + SmGamma : seed_q;
        U_XS1:  z_d = z_q ^ (z_q >> Xs1Shift);
        U_XS2:  z_d = z_q ^ (z_q >> Xs2Shift);
        U_MLL:  acc_d = prod;
        U_MLH:  acc_d = acc_q + {prod[31:0], 32'd0};
        U_MHL:  z_d = acc_q + {prod[31:0], 32'd0};
        U_MIXST: begin
          pass_d = !pass_q;
          if (pass_q) begin
            g_d[2] = {32'd0, mix_out[31:0]};
            g_d[3] = {32'd0, mix_out[63:32]};
          end else begin
            g_d[0] = {32'd0, mix_out[31:0]};
            g_d[1] = {32'd0, mix_out[63:32]};
          end
        end
        U_ADV:  g_d = advance(g_q);
        U_ADVD: begin
          g_d         = advance(g_q);
          last_d      = sum;
          out_valid_d = 1'b1;
          out_raw_d   = sum;
          out_frac_d  = sum[63:FracShift];
        end
        U_EMIT: begin
          out_valid_d = 1'b1;
          out_raw_d   = last_q;
          out_frac_d  = last_q[63:FracShift];
        end
        default: ;
      endcase
    end

    if (accept) begin
      op_d   = op_e'(req_i.opcode);
      seed_d = req_i.seed_value;
      pass_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= 1'b0;
      g_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_SEED;
    end else begin
      pass_q      <= pass_d;
      g_q         <= g_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q     <= seed_d;
    z_q        <= z_d;
    acc_q      <= acc_d;
    out_frac_q <= out_frac_d;
    out_raw_q  <= out_raw_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.sample_fraction = out_frac_q;
  assign rsp_o.raw_word        = out_raw_q;

  a_emit_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |=> out_valid_q && (out_raw_q == last_q))
    else $error("result does not match stored draw");

  a_frac_of_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_frac_q == out_raw_q[63:FracShift]))
    else $error("fraction inconsistent with raw word");

  a_stall_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(g_q) && $stable(last_q))
    else $error("generator changed during stall");

endmodule

>>> tb/xrs_draw_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the xoshiro256+ random source: predicts draws from requests and checks results.
module xrs_draw_scoreboard import xrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  xrs_in_if    req_i,
  xrs_out_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [FracW-1:0] frac;
    logic [63:0]      raw;
  } draw_t;

  logic [63:0] gen_q [4];
  logic [63:0] last_draw;
  draw_t       draws_q [$];
  draw_t       head;
  int          errors;

  function automatic logic [63:0] mix_word(input logic [63:0] z);
    logic [63:0] w;
    w = (z ^ (z >> Xs1Shift)) * SmMul1;
    w = (w ^ (w >> Xs2Shift)) * SmMul2;
    return w ^ (w >> Xs3Shift);
  endfunction

  task automatic reseed(input logic [63:0] seed);
    logic [63:0] a;
    logic [63:0] b;
    a = mix_word(seed);
    b = mix_word(seed + SmGamma);
    gen_q[0] = {32'h0, a[31:0]};
    gen_q[1] = {32'h0, a[63:32]};
    gen_q[2] = {32'h0, b[31:0]};
    gen_q[3] = {32'h0, b[63:32]};
  endtask

  task automatic advance_gen(output logic [63:0] sum);
    logic [63:0] t;
    sum = gen_q[0] + gen_q[3];
    t = gen_q[1] << AdvShift;
    gen_q[2] = gen_q[2] ^ gen_q[0];
    gen_q[3] = gen_q[3] ^ gen_q[1];
    gen_q[1] = gen_q[1] ^ gen_q[2];
    gen_q[0] = gen_q[0] ^ gen_q[3];
    gen_q[2] = gen_q[2] ^ t;
    gen_q[3] = (gen_q[3] << AdvRot) | (gen_q[3] >> (64 - AdvRot));
  endtask

  task automatic predict_request(input op_e op, input logic [63:0] seed);
    logic [63:0] sum;
    draw_t d;
    if (op == OP_SEED || op == OP_SEED_DRAW) reseed(seed);
    if (op != OP_SEED) begin
      if (op != OP_REPEAT) begin
        advance_gen(sum);
        advance_gen(sum);
        last_draw = sum;
      end
      d.frac = last_draw[63:FracShift];
      d.raw  = last_draw;
      draws_q.push_back(d);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) gen_q[k] = '0;
      last_draw = '0;
      draws_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (draws_q.size() == 0) begin
          $display("%0t: unexpected transaction, frac=%h raw=%h", $time,
                   rsp_i.sample_fraction, rsp_i.raw_word);
          errors++;
        end else begin
          head = draws_q.pop_front();
          if (rsp_i.sample_fraction !== head.frac) begin
            $display("%0t: sample_fraction expected %h actual %h", $time,
                     head.frac, rsp_i.sample_fraction);
            errors++;
          end
          if (rsp_i.raw_word !== head.raw) begin
            $display("%0t: raw_word expected %h actual %h", $time,
                     head.raw, rsp_i.raw_word);
            errors++;
          end
        end
      end
      if (req_i.valid && req_i.ready) predict_request(op_e'(req_i.opcode), req_i.seed_value);
      fail_count_o <= errors + draws_q.size() * 0;
      pending_o <= draws_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the xoshiro256+ random source: reset, stimulus, flow control and verdict.
module tb_top;
  import xrs_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 1250;
  localparam int unsigned CalmItems     = 125;
  localparam int unsigned DrainCycles   = 40;

  logic clk;
  logic rst_n;
  logic idle_on;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  int   stall_left;

  xrs_in_if  req_if ();
  xrs_out_if rsp_if ();

  xoshiro256plus_random_source_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  xrs_draw_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] pick_seed();
    logic [63:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      2:       s = -SmGamma;
      default: s = {$urandom, $urandom};
    endcase
    return s;
  endfunction

  task automatic send_request(input op_e op, input logic [63:0] seed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.seed_value <= seed;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    op_e op;
    int  r;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_SEED;
    req_if.seed_value = '0;
    idle_on           = 1'b0;
    rst_n             = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unseeded generator and empty last draw
    send_request(OP_REPEAT, '1);
    send_request(OP_DRAW, '1);
    send_request(OP_SEED, '0);
    send_request(OP_REPEAT, '0);
    send_request(OP_DRAW, '0);
    send_request(OP_REPEAT, 64'h0123_4567_89AB_CDEF);
    send_request(OP_SEED_DRAW, '1);
    send_request(OP_DRAW, '0);
    send_request(OP_SEED_DRAW, 64'h8000_0000_0000_0000);
    send_request(OP_SEED_DRAW, 64'h1);
    // back-to-back seeds, then draws from the second
    send_request(OP_SEED, '1);
    send_request(OP_SEED, 64'h5555_5555_5555_5555);
    send_request(OP_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_DRAW, '0);
    send_request(OP_DRAW, '1);
    // seed + gamma wraps to zero
    send_request(OP_SEED_DRAW, -SmGamma);
    send_request(OP_REPEAT, '0);
    send_request(OP_REPEAT, '1);
    send_request(OP_SEED, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_REPEAT, '0);

    idle_on <= 1'b1;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % CalmItems == 0)
        idle_on <= (i < RandomItems - CalmItems) && ($urandom_range(0, 3) != 0);
      if (i == 300 || i == RandomItems / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 12)      op = OP_SEED;
      else if (r < 55) op = OP_DRAW;
      else if (r < 70) op = OP_REPEAT;
      else             op = OP_SEED_DRAW;
      send_request(op, pick_seed());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
